// ===== hdl/phfe_pkg.sv =====
// Shared types and constants for the packet header feature extractor.
package phfe_pkg;

  localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
  localparam logic [15:0] IPV4_HDR_END  = 16'd34;
  localparam logic [15:0] TYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] TCP_HDR_NEED  = 16'd14;
  localparam logic [15:0] UDP_HDR_NEED  = 16'd4;

  // Byte offsets within the frame
  localparam logic [15:0] POS_TYPE_HI   = 16'd12;
  localparam logic [15:0] POS_TYPE_LO   = 16'd13;
  localparam logic [15:0] POS_IHL       = 16'd14;
  localparam logic [15:0] POS_PROTO     = 16'd23;
  localparam logic [15:0] POS_SRC_FIRST = 16'd26;
  localparam logic [15:0] POS_SRC_LAST  = 16'd29;
  localparam logic [15:0] POS_DST_FIRST = 16'd30;
  localparam logic [15:0] POS_DST_LAST  = 16'd33;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  // Offsets within the transport header
  localparam logic [15:0] OFF_SPORT_HI  = 16'd0;
  localparam logic [15:0] OFF_SPORT_LO  = 16'd1;
  localparam logic [15:0] OFF_DPORT_HI  = 16'd2;
  localparam logic [15:0] OFF_DPORT_LO  = 16'd3;
  localparam logic [15:0] OFF_TCP_FLAGS = 16'd13;

  // Protocol codes of the result
  localparam logic [1:0] CODE_TCP    = 2'd0;
  localparam logic [1:0] CODE_UDP    = 2'd1;
  localparam logic [1:0] CODE_NON_IP = 2'd2;
  localparam logic [1:0] CODE_OTHER  = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] wire_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  protocol_code;
    logic [15:0] frame_length;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic        syn_bit;
    logic        ack_bit;
    logic        rst_bit;
    logic        fin_bit;
    logic        short_frame;
  } rsp_t;

endpackage

// ===== hdl/packet_header_feature_extractor.sv =====
// Top level: input register, header parser and result register of the feature extractor.
// A request passes the input register and the parser; a last byte's record then loads the result register.
// Throughput: one byte request per cycle; only a stalled record holds a last-byte request in the input register.
// The input register and the result register part the two sides, so bytes that end no frame
// keep flowing while a finished record waits to be taken.
// Reset (rst, synchronous, active high) empties both registers and clears the frame state.
module packet_header_feature_extractor (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  phfe_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output phfe_pkg::rsp_t res
);

  logic           s1_valid;
  phfe_pkg::req_t s1_req;
  logic           advance;
  phfe_pkg::rsp_t result;

  // A byte that ends no frame always moves on; a last byte needs room in the result register
  assign advance   = s1_valid && (!s1_req.last_byte || !res_valid || res_ready);
  assign req_ready = !s1_valid || advance;

  // Input register: hold the request until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_req <= req;
    end
  end

  // Header capture and the record of the frame that ends with this byte
  phfe_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .take   (advance),
    .req    (s1_req),
    .result (result)
  );

  // Result register: load on a frame's last byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && s1_req.last_byte) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_req.last_byte) begin
      res <= result;
    end
  end

endmodule

// ===== hdl/phfe_parse.sv =====
// Frame state and per-byte header capture, with the feature record of the frame.
module phfe_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  phfe_pkg::req_t    req,
  output phfe_pkg::rsp_t    result
);

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] type_word, type_word_next;
  logic [3:0]  header_words, header_words_next;
  logic [7:0]  transport_kind, transport_kind_next;
  logic [31:0] src_addr_reg, src_addr_next;
  logic [31:0] dst_addr_reg, dst_addr_next;
  logic [15:0] src_port_reg, src_port_next;
  logic [15:0] dst_port_reg, dst_port_next;
  logic [3:0]  flag_bits, flag_bits_next;

  logic [15:0] pos;
  logic [15:0] base_type, base_sport, base_dport;
  logic [3:0]  base_words, ihl, base_flags;
  logic [7:0]  base_kind, b;
  logic [31:0] base_src, base_dst;
  logic [15:0] ts, off, ts_res;
  logic        in_transport, ip;

  // Start from a clean frame when the byte opens one
  always_comb begin
    b          = req.data_byte;
    pos        = req.first_byte ? '0 : byte_position;
    base_type  = req.first_byte ? '0 : type_word;
    base_words = req.first_byte ? '0 : header_words;
    base_kind  = req.first_byte ? '0 : transport_kind;
    base_src   = req.first_byte ? '0 : src_addr_reg;
    base_dst   = req.first_byte ? '0 : dst_addr_reg;
    base_sport = req.first_byte ? '0 : src_port_reg;
    base_dport = req.first_byte ? '0 : dst_port_reg;
    base_flags = req.first_byte ? '0 : flag_bits;
  end

  always_comb begin
    type_word_next      = base_type;
    header_words_next   = base_words;
    transport_kind_next = base_kind;
    src_addr_next       = base_src;
    dst_addr_next       = base_dst;
    src_port_next       = base_sport;
    dst_port_next       = base_dport;
    flag_bits_next      = base_flags;

    if (pos == phfe_pkg::POS_TYPE_HI) type_word_next = {b, base_type[7:0]};
    if (pos == phfe_pkg::POS_TYPE_LO) type_word_next = {base_type[15:8], b};
    if (pos == phfe_pkg::POS_IHL) header_words_next = b[3:0];
    if (pos == phfe_pkg::POS_PROTO) transport_kind_next = b;
    if (pos >= phfe_pkg::POS_SRC_FIRST && pos <= phfe_pkg::POS_SRC_LAST) begin
      src_addr_next = {base_src[23:0], b};
    end
    if (pos >= phfe_pkg::POS_DST_FIRST && pos <= phfe_pkg::POS_DST_LAST) begin
      dst_addr_next = {base_dst[23:0], b};
    end

    // Transport header start; the IHL byte itself may already be part of it
    ihl          = (pos == phfe_pkg::POS_IHL) ? b[3:0] : base_words;
    ts           = phfe_pkg::ETH_HDR_BYTES + {10'd0, ihl, 2'b00};
    in_transport = (pos >= phfe_pkg::ETH_HDR_BYTES) && (pos >= ts);
    off          = pos - ts;
    if (in_transport) begin
      case (off)
        phfe_pkg::OFF_SPORT_HI:  src_port_next = {b, base_sport[7:0]};
        phfe_pkg::OFF_SPORT_LO:  src_port_next = {base_sport[15:8], b};
        phfe_pkg::OFF_DPORT_HI:  dst_port_next = {b, base_dport[7:0]};
        phfe_pkg::OFF_DPORT_LO:  dst_port_next = {base_dport[15:8], b};
        phfe_pkg::OFF_TCP_FLAGS: flag_bits_next = {b[4], b[2], b[1], b[0]};
        default: ;
      endcase
    end

    byte_position_next = (pos == phfe_pkg::POS_MAX) ? pos : pos + 16'd1;
  end

  // Build the record from the state as it stands after this byte
  always_comb begin
    ip     = (byte_position_next >= phfe_pkg::ETH_HDR_BYTES) &&
             (type_word_next == phfe_pkg::TYPE_IPV4);
    ts_res = phfe_pkg::ETH_HDR_BYTES + {10'd0, header_words_next, 2'b00};
    result = '0;
    result.frame_length = req.wire_length;
    if (!ip) begin
      result.protocol_code = phfe_pkg::CODE_NON_IP;
      result.short_frame   = byte_position_next < phfe_pkg::ETH_HDR_BYTES;
    end else if (transport_kind_next == phfe_pkg::PROTO_TCP) begin
      result.protocol_code = phfe_pkg::CODE_TCP;
      result.short_frame   = (byte_position_next < phfe_pkg::IPV4_HDR_END) ||
                             (byte_position_next < ts_res + phfe_pkg::TCP_HDR_NEED);
    end else if (transport_kind_next == phfe_pkg::PROTO_UDP) begin
      result.protocol_code = phfe_pkg::CODE_UDP;
      result.short_frame   = (byte_position_next < phfe_pkg::IPV4_HDR_END) ||
                             (byte_position_next < ts_res + phfe_pkg::UDP_HDR_NEED);
    end else begin
      result.protocol_code = phfe_pkg::CODE_OTHER;
      result.short_frame   = byte_position_next < phfe_pkg::IPV4_HDR_END;
    end
    if (ip) begin
      result.source_address      = src_addr_next;
      result.destination_address = dst_addr_next;
    end
    if (ip && (transport_kind_next == phfe_pkg::PROTO_TCP ||
               transport_kind_next == phfe_pkg::PROTO_UDP)) begin
      result.source_port      = src_port_next;
      result.destination_port = dst_port_next;
    end
    if (ip && transport_kind_next == phfe_pkg::PROTO_TCP) begin
      result.syn_bit = flag_bits_next[1];
      result.ack_bit = flag_bits_next[3];
      result.rst_bit = flag_bits_next[2];
      result.fin_bit = flag_bits_next[0];
    end
  end

  // Drop the frame state once its last byte has gone through
  always_ff @(posedge clk) begin
    if (rst || (take && req.last_byte)) begin
      byte_position  <= '0;
      type_word      <= '0;
      header_words   <= '0;
      transport_kind <= '0;
      src_addr_reg   <= '0;
      dst_addr_reg   <= '0;
      src_port_reg   <= '0;
      dst_port_reg   <= '0;
      flag_bits      <= '0;
    end else if (take) begin
      byte_position  <= byte_position_next;
      type_word      <= type_word_next;
      header_words   <= header_words_next;
      transport_kind <= transport_kind_next;
      src_addr_reg   <= src_addr_next;
      dst_addr_reg   <= dst_addr_next;
      src_port_reg   <= src_port_next;
      dst_port_reg   <= dst_port_next;
      flag_bits      <= flag_bits_next;
    end
  end

endmodule

// ===== hdl/phfe_checker.sv =====
// Port-level checks of the feature extractor, bound to the top level.
module phfe_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_ready,
  input logic           res_valid,
  input logic           res_ready,
  input phfe_pkg::rsp_t res
);

  // Both registers come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid && req_ready)
    else $error("block not empty after reset");

  // A stalled record holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled record changed");

  // A non-IP record carries no addresses or ports
  a_non_ip_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.protocol_code == phfe_pkg::CODE_NON_IP |->
      res.source_address == '0 && res.destination_address == '0 &&
      res.source_port == '0 && res.destination_port == '0)
    else $error("non-IP record with address or port fields");

  // TCP flags appear only in TCP records
  a_flags_tcp_only: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.protocol_code != phfe_pkg::CODE_TCP |->
      !res.syn_bit && !res.ack_bit && !res.rst_bit && !res.fin_bit)
    else $error("TCP flags set in a non-TCP record");

endmodule

bind packet_header_feature_extractor phfe_checker u_phfe_checker (.*);
